[hdl/tcw_pkg.sv]
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int POS_W   = 11;

   localparam logic [15:0] BLANK_CELL = 16'h0020;

   typedef enum logic [1:0] {
      REQ_PUT     = 2'd0,
      REQ_NEWLINE = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_READ    = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   character;
      logic [3:0]   foreground;
      logic [3:0]   background;
      logic [10:0]  cell_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
      logic [POS_W-1:0] cursor_pos;
      logic             scrolled;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_NEWLINE,
      ST_CLEAR,
      ST_READ,
      ST_READ_DATA,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK_ROW,
      ST_DONE
   } state_type;

   // Source of the memory write issued by the controller
   typedef enum logic [1:0] {
      WR_NONE,
      WR_CHAR,
      WR_BLANK_CURSOR,
      WR_BLANK_SWEEP
   } wr_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_ZERO,
      CUR_LAST_ROW
   } cur_op_type;

   typedef struct packed {
      logic       load;
      logic       sweep_clr;
      logic       sweep_inc;
      logic       copy_rd;
      logic       rd_capture;
      logic       scr_set;
      logic       rsp_load;
      wr_sel_type wr_sel;
      cur_op_type cur_op;
   } tcw_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic copy_last;
      logic cur_wrap;
      logic col_last;
   } tcw_stat_type;

endpackage

[hdl/tcw_dpath.sv]
module tcw_dpath
   import tcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  tcw_cmd_type  cmd,
   output tcw_stat_type stat,
   output rsp_item_type rsp_item
);

   logic [15:0]       mem_ff [CELLS];
   logic [15:0]       rdata_ff;
   req_item_type      req_ff;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] sweep_ff;
   logic              copy_pend_ff;
   logic [CELL_W-1:0] copy_wa_ff;
   logic              scr_ff;
   logic [7:0]        rchar_ff;
   logic [7:0]        rattr_ff;
   rsp_item_type      rsp_ff;

   logic              we;
   logic [CELL_W-1:0] wa;
   logic [15:0]       wd;
   logic [CELL_W-1:0] ra;
   logic              idx_ok;

   assign idx_ok = 32'(req_ff.cell_index) < CELLS;

   assign stat.sweep_last = sweep_ff == CELL_W'(CELLS - 1);
   assign stat.copy_last  = sweep_ff == CELL_W'(CELLS - COLUMNS - 1);
   assign stat.cur_wrap   = cursor_ff == CELL_W'(CELLS - 1);
   assign stat.col_last   = col_ff == COL_W'(COLUMNS - 1);

   // A pending copy write owns the port; the controller drains it first
   always_comb begin
      we = 1'b0;
      wa = sweep_ff;
      wd = BLANK_CELL;
      if (copy_pend_ff) begin
         we = 1'b1;
         wa = copy_wa_ff;
         wd = rdata_ff;
      end else begin
         unique case (cmd.wr_sel)
            WR_NONE: begin
               we = 1'b0;
            end
            WR_CHAR: begin
               we = 1'b1;
               wa = cursor_ff;
               wd = {req_ff.background, req_ff.foreground, req_ff.character};
            end
            WR_BLANK_CURSOR: begin
               we = 1'b1;
               wa = cursor_ff;
            end
            WR_BLANK_SWEEP: begin
               we = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.copy_rd) begin
         ra = CELL_W'(32'(sweep_ff) + COLUMNS);
      end else if (idx_ok) begin
         ra = CELL_W'(req_ff.cell_index);
      end else begin
         ra = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rdata_ff <= mem_ff[ra];
   end

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: begin
            cursor_in = cursor_ff;
         end
         CUR_INC: begin
            cursor_in = cursor_ff + 1'b1;
            col_in    = stat.col_last ? '0 : col_ff + 1'b1;
         end
         CUR_ZERO: begin
            cursor_in = '0;
            col_in    = '0;
         end
         CUR_LAST_ROW: begin
            cursor_in = CELL_W'(CELLS - COLUMNS);
            col_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         copy_pend_ff <= cmd.copy_rd;
         if (cmd.sweep_clr) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_inc) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_wa_ff <= sweep_ff;
      if (cmd.load) begin
         req_ff   <= req_item;
         scr_ff   <= 1'b0;
         rchar_ff <= '0;
         rattr_ff <= '0;
      end else begin
         if (cmd.scr_set) begin
            scr_ff <= 1'b1;
         end
         if (cmd.rd_capture && idx_ok) begin
            rchar_ff <= rdata_ff[7:0];
            rattr_ff <= rdata_ff[15:8];
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.cell_char  <= rchar_ff;
         rsp_ff.cell_attr  <= rattr_ff;
         rsp_ff.cursor_pos <= POS_W'(cursor_ff);
         rsp_ff.scrolled   <= scr_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

[hdl/tcw_ctrl.sv]
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_kind_type req_kind,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  tcw_stat_type stat,
   output tcw_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  REQ_PUT:     state_in = ST_PUT;
                  REQ_NEWLINE: state_in = ST_NEWLINE;
                  REQ_CLEAR:   state_in = ST_CLEAR;
                  REQ_READ:    state_in = ST_READ;
               endcase
            end
         end
         ST_PUT: begin
            state_in = stat.cur_wrap ? ST_COPY : ST_DONE;
         end
         ST_NEWLINE: begin
            if (stat.cur_wrap) begin
               state_in = ST_COPY;
            end else if (stat.col_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            if (stat.sweep_last) state_in = ST_DONE;
         end
         ST_READ:      state_in = ST_READ_DATA;
         ST_READ_DATA: state_in = ST_DONE;
         ST_COPY: begin
            if (stat.copy_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:     state_in = ST_BLANK_ROW;
         ST_BLANK_ROW: begin
            if (stat.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd = '{load: 1'b0, sweep_clr: 1'b0, sweep_inc: 1'b0, copy_rd: 1'b0,
              rd_capture: 1'b0, scr_set: 1'b0, rsp_load: 1'b0,
              wr_sel: WR_NONE, cur_op: CUR_HOLD};
      unique case (state_ff)
         ST_INIT: begin
            cmd.wr_sel    = WR_BLANK_SWEEP;
            cmd.sweep_inc = 1'b1;
         end
         ST_IDLE: begin
            cmd.load      = accept;
            cmd.sweep_clr = 1'b1;
         end
         ST_PUT: begin
            cmd.wr_sel = WR_CHAR;
            if (stat.cur_wrap) cmd.scr_set = 1'b1;
            else               cmd.cur_op  = CUR_INC;
         end
         ST_NEWLINE: begin
            cmd.wr_sel = WR_BLANK_CURSOR;
            if (stat.cur_wrap) cmd.scr_set = 1'b1;
            else               cmd.cur_op  = CUR_INC;
         end
         ST_CLEAR: begin
            cmd.wr_sel    = WR_BLANK_SWEEP;
            cmd.sweep_inc = 1'b1;
            if (stat.sweep_last) cmd.cur_op = CUR_ZERO;
         end
         ST_READ: begin
         end
         ST_READ_DATA: begin
            cmd.rd_capture = 1'b1;
         end
         ST_COPY: begin
            cmd.copy_rd   = 1'b1;
            cmd.sweep_inc = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_BLANK_ROW: begin
            cmd.wr_sel    = WR_BLANK_SWEEP;
            cmd.sweep_inc = 1'b1;
            if (stat.sweep_last) cmd.cur_op = CUR_LAST_ROW;
         end
         ST_DONE: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/text_console_writer.sv]
// Text console writer: a screen of ROWS x COLUMNS cells (character in the low
// byte, attribute in the high byte) held in one on-chip memory, plus a cursor.
// Every request gives exactly one result item carrying the cursor after the
// request and a scroll flag; a read also returns the cell (zero when the index
// lies off the screen). After reset the block blanks the whole screen, one cell
// per clock, so req_ready stays low until all ROWS*COLUMNS cells (2000 by
// default) are blank. Steps from accept to the result in the output register:
//   put character : write the character at the cursor and advance the cursor
//   new line      : blank the cells up to the next line start
//   read cell     : registered memory read, then capture of the cell
//   clear screen  : blank every cell, then return the cursor to zero
// A put or new line that runs off the end scrolls: the memory copies each row
// up through its single read and single write port, one cell per cycle, then
// blanks the last row. The next request is taken while the previous result
// still waits on the rsp side.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   tcw_cmd_type  cmd;
   tcw_stat_type stat;

   // Sequence each request, including the clearing, copy and blanking sweeps
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the screen memory, cursor, sweep counter and result register
   tcw_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

   // One item in flight: accepting an item makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an accepted item");

   // A scroll always leaves the cursor at the start of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.scrolled |->
         rsp_item.cursor_pos == POS_W'(CELLS - COLUMNS))
      else $error("scroll left the cursor off the last row start");

   // Leaving reset starts the clearing pass, no item taken
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("item handshake open during the clearing pass");

   // The memory port is never driven by the controller while a copy drains
   a_copy_port: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_rd |=> cmd.wr_sel == WR_NONE)
      else $error("write port conflict during scroll copy");

endmodule
